/* rtl/pnt_pkg.sv */
// Shared widths and types for the perfect number test block.
`timescale 1ns / 1ps

package pnt_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
	localparam int ACC_W      = DATA_WIDTH + 2;

	typedef struct packed {
		logic                  done;
		logic [DATA_WIDTH-1:0] quo;
		logic                  rem_zero;
	} pnt_div_res_t;

endpackage

/* rtl/pnt_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module pnt_div
	import pnt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output pnt_div_res_t          res
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH:0]   rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] dsr_q;

	logic [DATA_WIDTH:0]   rem_shift;
	logic [DATA_WIDTH:0]   rem_diff;
	logic                  take;

	// bring down the next dividend bit from the top of the quotient register
	assign rem_shift = {rem_q[DATA_WIDTH-1:0], quo_q[DATA_WIDTH-1]};
	assign take      = rem_shift >= {1'b0, dsr_q};
	assign rem_diff  = rem_shift - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// flag the cycle after the last quotient bit
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? rem_diff : rem_shift;
			quo_q <= {quo_q[DATA_WIDTH-2:0], take};
		end
	end

	assign res.done     = done_q;
	assign res.quo      = quo_q;
	assign res.rem_zero = (rem_q == '0);

endmodule

/* rtl/perfect_number_test.sv */
// Top level of the perfect number test: trial division sequencer and result register.
//
//   channel | signals                       | direction | payload
//   --------+-------------------------------+-----------+------------------------------
//   request | req_valid, req_stall, number  | into      | number, DATA_WIDTH bits signed
//   result  | rsp_valid, rsp_stall          | out of    | is_perfect, 1 bit
//
// Trial divisors d count up from 2; each one runs a division in the bit-serial
// divider, followed by ST_ADDQ and ST_CHK when d divides n; the search ends once
// d > n/d or the divisor sum passes n. Values below 2 and negatives go straight
// to ST_DONE with no search.
// Reset (arst_n low) empties the sequencer and the result register.
// A request is taken only while the sequencer is idle; a result waits in its
// register under rsp_stall while the next request is accepted and searched.
`timescale 1ns / 1ps

module perfect_number_test
	import pnt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [DATA_WIDTH-1:0] number,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  is_perfect
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ADDQ = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]            state_q;
	logic                  start_q;
	logic [DATA_WIDTH-1:0] n_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [DATA_WIDTH-1:0] q_q;
	logic [ACC_W-1:0]      acc_q;
	logic                  res_q;
	logic                  rsp_valid_q;
	logic                  is_perfect_q;

	pnt_div_res_t          div_res;
	logic                  req_beat;
	logic                  trivial;
	logic [ACC_W-1:0]      n_ext;

	assign req_stall = (state_q != ST_IDLE);
	assign req_beat  = req_valid && !req_stall;
	// negative, zero and one never search
	assign trivial   = number[DATA_WIDTH-1] || (number <= DATA_WIDTH'(1));
	assign n_ext     = {2'b00, n_q};

	pnt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (n_q),
		.divisor  (d_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// load the result register when a finished item finds it free
			if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					start_q <= req_beat && !trivial;
					if (req_beat) begin
						if (trivial) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						if (d_q > div_res.quo) begin
							state_q <= ST_DONE;
							start_q <= 1'b0;
						end else if (div_res.rem_zero) begin
							state_q <= ST_ADDQ;
							start_q <= 1'b0;
						end else begin
							start_q <= 1'b1;
						end
					end else begin
						start_q <= 1'b0;
					end
				end
				ST_ADDQ: begin
					state_q <= ST_CHK;
					start_q <= 1'b0;
				end
				ST_CHK: begin
					if (acc_q > n_ext) begin
						state_q <= ST_DONE;
						start_q <= 1'b0;
					end else begin
						state_q <= ST_DIV;
						start_q <= 1'b1;
					end
				end
				ST_DONE: begin
					start_q <= 1'b0;
					// hold until the result register is free
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					start_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_beat) begin
					n_q   <= number;
					d_q   <= DATA_WIDTH'(2);
					acc_q <= ACC_W'(1);
					res_q <= 1'b0;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					if (d_q > div_res.quo) begin
						res_q <= (acc_q == n_ext);
					end else if (div_res.rem_zero) begin
						acc_q <= acc_q + {2'b00, d_q};
						q_q   <= div_res.quo;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
			end
			ST_ADDQ: begin
				// a square divisor counts once
				if (q_q != d_q) begin
					acc_q <= acc_q + {2'b00, q_q};
				end
			end
			ST_CHK: begin
				if (acc_q > n_ext) begin
					res_q <= 1'b0;
				end else begin
					d_q <= d_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					is_perfect_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid  = rsp_valid_q;
	assign is_perfect = is_perfect_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider finished outside a trial");

	a_acc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> acc_q <= n_ext)
		else $error("divisor sum passed the number during the search");

	a_start_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> state_q == ST_DIV && d_q >= DATA_WIDTH'(2))
		else $error("divider started outside the search");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !(rsp_valid_q && rsp_stall)) |=> state_q == ST_IDLE && rsp_valid_q)
		else $error("finished result not moved to the output register");

endmodule

/* sim/perfect_number_test_tb.sv */
// Self-checking testbench for the perfect number test block.
`timescale 1ns / 1ps

module perfect_number_test_tb;
	import pnt_pkg::*;

	typedef enum int {
		PH_FREE,
		PH_SLOW_SEND,
		PH_SLOW_RECV,
		PH_BOTH,
		PH_HOLD
	} phase_t;

	typedef struct {
		logic [DATA_WIDTH-1:0] value;
		int                    verdict;
	} row_t;

	localparam int PREDICT      = -1;
	localparam int HOLD_CYCLES  = 3000;
	localparam int QUIET_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 18;
	localparam int HOLD_ITEMS   = 6;
	localparam int DRAIN_CYCLES = 200;
	localparam int REPORT_MAX   = 10;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	logic [DATA_WIDTH-1:0] number;
	logic                  rsp_valid;
	logic                  rsp_stall;
	logic                  is_perfect;

	phase_t phase = PH_FREE;
	int     send_idle = 0;
	int     stall_pct = 0;
	bit     hold_done = 1'b0;
	int     n_sent = 0;
	int     n_checked = 0;
	int     mismatches = 0;
	int     quiet = 0;
	int     typed_q[$];
	bit     verdict_q[$];

	// extremes, special values and the small perfect numbers
	row_t directed [21] = '{
		'{32'd0, 0},
		'{32'd1, 0},
		'{32'd2, 0},
		'{32'd3, PREDICT},
		'{32'd4, PREDICT},
		'{32'd7, PREDICT},
		'{32'd9, PREDICT},
		'{32'd25, PREDICT},
		'{32'd6, 1},
		'{32'd28, 1},
		'{32'd496, 1},
		'{32'd8128, 1},
		'{32'd33550336, 1},
		'{32'd12, PREDICT},
		'{32'd24, PREDICT},
		'{32'd120, PREDICT},
		'{32'd945, PREDICT},
		'{32'h8000_0000, 0},
		'{32'hFFFF_FFFF, 0},
		'{32'hFFFF_FFFA, 0},
		'{32'h7FFF_FFF8, PREDICT}
	};

	perfect_number_test dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.number     (number),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.is_perfect (is_perfect)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Trial division over divisor pairs, in a 64-bit sum that cannot wrap.
	function automatic bit perfect_verdict(input logic [DATA_WIDTH-1:0] value);
		bit [63:0] n;
		bit [63:0] acc;
		bit [63:0] d;
		bit [63:0] q;
		if (value[DATA_WIDTH-1])
			return 1'b0;
		n = 64'(value);
		if (n <= 64'd1)
			return 1'b0;
		acc = 64'd1;
		for (d = 64'd2; d <= n / d; d++) begin
			if (n % d == 64'd0) begin
				q = n / d;
				acc += d;
				if (q != d)
					acc += q;
				if (acc > n)
					return 1'b0;
			end
		end
		return acc == n;
	endfunction

	// Keep large positives cheap for the block: multiples of 12 leave the search early.
	function automatic logic [DATA_WIDTH-1:0] random_number();
		int unsigned r;
		case ($urandom_range(9))
			0, 1: return {1'b1, 31'($urandom)};
			2: begin
				r = $urandom_range(32'h7FFF_FFFF, 24);
				return 32'(r - r % 12);
			end
			3: case ($urandom_range(3))
				0: return 32'd6;
				1: return 32'd28;
				2: return 32'd496;
				default: return 32'd8128;
			endcase
			4: case ($urandom_range(3))
				0: return 32'd0;
				1: return 32'd1;
				2: return 32'd2;
				default: return 32'hFFFF_FFFF;
			endcase
			default: return 32'($urandom_range(5000, 2));
		endcase
	endfunction

	task automatic note_mismatch(input string what, input bit want, input logic got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%t mismatch (%s): expected is_perfect=%0b, got %0b", $realtime, what,
				want, got);
	endtask

	task automatic send_number(input logic [DATA_WIDTH-1:0] value, input int verdict);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		typed_q.push_back(verdict);
		req_valid <= 1'b1;
		number    <= value;
		do @(posedge clk); while (req_stall);
		n_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (n_checked < n_sent)
			@(posedge clk);
	endtask

	task automatic set_phase(input phase_t p);
		phase = p;
		case (p)
			PH_SLOW_SEND: begin send_idle = 74; stall_pct = 0;  end
			PH_SLOW_RECV: begin send_idle = 0;  stall_pct = 74; end
			PH_BOTH:      begin send_idle = 14; stall_pct = 14; end
			default:      begin send_idle = 0;  stall_pct = 0;  end
		endcase
	endtask

	// receiver: random stalls, plus one long hold-off counted here
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (phase == PH_HOLD && !hold_done) begin
				rsp_stall <= 1'b1;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
				hold_done = 1'b1;
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		int typed;
		bit want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				typed = typed_q.size() != 0 ? typed_q.pop_front() : PREDICT;
				verdict_q.push_back(typed == PREDICT ? perfect_verdict(number) : typed[0]);
			end
			if (rsp_valid && !rsp_stall) begin
				if (verdict_q.size() == 0) begin
					note_mismatch("result with none expected", 1'b0, is_perfect);
				end else begin
					want = verdict_q.pop_front();
					if (is_perfect !== want)
						note_mismatch("is_perfect", want, is_perfect);
					n_checked++;
				end
			end
		end
	end

	// watchdog on cycles in which neither channel moves a beat
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("perfect_number_test verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		number    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_phase(PH_FREE);
		foreach (directed[i])
			send_number(directed[i].value, directed[i].verdict);
		drain();

		// hold results back while the sender keeps offering beats
		set_phase(PH_HOLD);
		for (int i = 0; i < HOLD_ITEMS; i++)
			send_number(32'($urandom_range(300, 2)), PREDICT);
		wait (hold_done);
		drain();

		for (int p = PH_FREE; p <= PH_BOTH; p++) begin
			set_phase(phase_t'(p));
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_number(random_number(), PREDICT);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("perfect_number_test verification clean");
		else
			$display("perfect_number_test verification failed");
		$finish;
	end

endmodule
